// File: hdl/ble_adf_pkg.sv
`default_nettype none

package ble_adf_pkg;

   // register map of the csr channel
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UUID_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UUID_HIGH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UUID_LEN  = 2'd2;

   localparam logic [4:0] UUID_LEN_RESET = 5'd2;

   // uuid sizes in bytes
   localparam logic [4:0] UUID_BYTES_16  = 5'd2;
   localparam logic [4:0] UUID_BYTES_32  = 5'd4;
   localparam logic [4:0] UUID_BYTES_128 = 5'd16;

   // AD record types
   localparam logic [7:0] AD_LIST16_PART  = 8'h02;
   localparam logic [7:0] AD_LIST16_FULL  = 8'h03;
   localparam logic [7:0] AD_LIST32_PART  = 8'h04;
   localparam logic [7:0] AD_LIST32_FULL  = 8'h05;
   localparam logic [7:0] AD_LIST128_PART = 8'h06;
   localparam logic [7:0] AD_LIST128_FULL = 8'h07;
   localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
   localparam logic [7:0] AD_NAME_FULL    = 8'h09;
   localparam logic [7:0] AD_SVC_DATA16   = 8'h16;
   localparam logic [7:0] AD_SVC_DATA32   = 8'h20;
   localparam logic [7:0] AD_SVC_DATA128  = 8'h21;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] pos;
      phase_type  phase;
      logic       stopped;
      logic [7:0] remain;
      logic [7:0] rtype;
      logic [7:0] dstart;
      logic [4:0] cidx;
      logic       cmatch;
      logic       rhit;
      logic [1:0] seen;
      logic       svc_hit;
      logic       full_found;
      logic [7:0] full_off;
      logic [7:0] full_len;
      logic       short_found;
      logic [7:0] short_off;
      logic [7:0] short_len;
      logic       sd_done;
      logic       sd_found;
      logic [7:0] sd_off;
      logic [7:0] sd_len;
   } pkt_state_type;

   localparam pkt_state_type PKT_CLEAR = '{
      pos:         8'd0,
      phase:       PH_LEN,
      stopped:     1'b0,
      remain:      8'd0,
      rtype:       8'd0,
      dstart:      8'd0,
      cidx:        5'd0,
      cmatch:      1'b1,
      rhit:        1'b0,
      seen:        2'b00,
      svc_hit:     1'b0,
      full_found:  1'b0,
      full_off:    8'd0,
      full_len:    8'd0,
      short_found: 1'b0,
      short_off:   8'd0,
      short_len:   8'd0,
      sd_done:     1'b0,
      sd_found:    1'b0,
      sd_off:      8'd0,
      sd_len:      8'd0
   };

endpackage

`default_nettype wire

// File: hdl/ble_adf_if.sv
`default_nettype none

interface ble_adf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] adv_byte;
   logic       last_byte;

   modport source (output valid, output adv_byte, output last_byte, input ready);
   modport sink   (input valid, input adv_byte, input last_byte, output ready);
endinterface

interface ble_adf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_offset;
   logic [7:0] name_length;
   logic       has_service;
   logic       service_data_found;
   logic [7:0] service_data_offset;
   logic [7:0] service_data_length;

   modport source (output valid, output name_offset, output name_length,
                   output has_service, output service_data_found,
                   output service_data_offset, output service_data_length,
                   input ready);
   modport sink   (input valid, input name_offset, input name_length,
                   input has_service, input service_data_found,
                   input service_data_offset, input service_data_length,
                   output ready);
endinterface

interface ble_adf_csr_if;
   import ble_adf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [63:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ble_adv_data_filter_unit.sv
// A last byte accepted into the input register loads the result register when it advances;
// rsp valid is high from then on, until the result is taken.
// Throughput: one advertising byte per cycle. A last byte waits in the input register
// only while an unread result still holds the result register; other bytes keep flowing.
// All record walking for a byte is done between those two registers.
// Reset (synchronous, active high) clears the packet state, empties both
// registers and loads uuid_low/uuid_high with 0 and uuid_length with 2.
`default_nettype none

module ble_adv_data_filter_unit #(
   parameter int unsigned MAX_PACKET_BYTES = 255
) (
   input wire logic      clock,
   input wire logic      reset,
   ble_adf_req_if.sink   req_chan,
   ble_adf_rsp_if.source rsp_chan,
   ble_adf_csr_if.sink   csr_chan
);
   import ble_adf_pkg::*;

   localparam logic [7:0] MAX_POS = 8'(MAX_PACKET_BYTES);

   // configuration
   logic [63:0]  uuid_low_ff;
   logic [63:0]  uuid_high_ff;
   logic [4:0]   uuid_len_ff;
   logic [127:0] uuid_all;
   logic [7:0]   ulen8;
   logic         ulen_ok;
   logic [7:0]   t_full;
   logic [7:0]   t_part;
   logic [7:0]   t_sdata;

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       req_fire;

   // packet state
   pkt_state_type st_ff;
   pkt_state_type st_in;
   pkt_state_type nx;

   logic       is_list;
   logic       is_sdata;
   logic [7:0] chunk_byte;
   logic [4:0] cidx_inc;
   logic       do_commit;
   logic [7:0] c_ty;
   logic [7:0] c_start;
   logic [7:0] c_plen;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] name_off_ff;
   logic [7:0] name_len_ff;
   logic       has_svc_ff;
   logic       sd_found_ff;
   logic [7:0] sd_off_ff;
   logic [7:0] sd_len_ff;

   // ---------------------------------------------------------------- csr
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_low_ff  <= '0;
         uuid_high_ff <= '0;
         uuid_len_ff  <= UUID_LEN_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_UUID_LOW:  uuid_low_ff  <= csr_chan.data;
            CSR_UUID_HIGH: uuid_high_ff <= csr_chan.data;
            CSR_UUID_LEN:  uuid_len_ff  <= csr_chan.data[4:0];
            default: ;
         endcase
      end
   end

   assign uuid_all = {uuid_high_ff, uuid_low_ff};
   assign ulen8    = {3'b000, uuid_len_ff};

   always_comb begin
      ulen_ok = 1'b1;
      t_full  = AD_LIST16_FULL;
      t_part  = AD_LIST16_PART;
      t_sdata = AD_SVC_DATA16;
      case (uuid_len_ff)
         UUID_BYTES_16: begin
            t_full  = AD_LIST16_FULL;
            t_part  = AD_LIST16_PART;
            t_sdata = AD_SVC_DATA16;
         end
         UUID_BYTES_32: begin
            t_full  = AD_LIST32_FULL;
            t_part  = AD_LIST32_PART;
            t_sdata = AD_SVC_DATA32;
         end
         UUID_BYTES_128: begin
            t_full  = AD_LIST128_FULL;
            t_part  = AD_LIST128_PART;
            t_sdata = AD_SVC_DATA128;
         end
         default: ulen_ok = 1'b0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   // a non-last byte never needs the result register
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.adv_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // -------------------------------------------------------- record walk
   assign chunk_byte = uuid_all[{st_ff.cidx[3:0], 3'b000} +: 8];
   assign cidx_inc   = st_ff.cidx + 5'd1;
   assign is_list    = ulen_ok && ((st_ff.rtype == t_full && !st_ff.seen[0]) ||
                                   (st_ff.rtype == t_part && !st_ff.seen[1]));
   assign is_sdata   = ulen_ok && st_ff.rtype == t_sdata && !st_ff.sd_done;

   always_comb begin
      nx        = st_ff;
      do_commit = 1'b0;
      c_ty      = st_ff.rtype;
      c_start   = st_ff.dstart;
      c_plen    = 8'd0;

      if (st_ff.pos < MAX_POS) begin
         if (!st_ff.stopped) begin
            case (st_ff.phase)
               PH_LEN: begin
                  if (in_byte_ff == 8'd0) begin
                     nx.stopped = 1'b1;
                  end else begin
                     nx.remain = in_byte_ff;
                     nx.phase  = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  nx.rtype  = in_byte_ff;
                  nx.dstart = st_ff.pos + 8'd1;
                  nx.cidx   = 5'd0;
                  nx.cmatch = 1'b1;
                  nx.rhit   = 1'b0;
                  nx.remain = st_ff.remain - 8'd1;
                  if (st_ff.remain == 8'd1) begin
                     do_commit = 1'b1;
                     c_ty      = in_byte_ff;
                     c_start   = st_ff.pos + 8'd1;
                     nx.phase  = PH_LEN;
                  end else begin
                     nx.phase = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (is_list) begin
                     if (in_byte_ff != chunk_byte) begin
                        nx.cmatch = 1'b0;
                     end
                     if (cidx_inc >= uuid_len_ff) begin
                        // chunk complete: fold into record hit, start next chunk
                        if (nx.cmatch) begin
                           nx.rhit = 1'b1;
                        end
                        nx.cidx   = 5'd0;
                        nx.cmatch = 1'b1;
                     end else begin
                        nx.cidx = cidx_inc;
                     end
                  end else if (is_sdata) begin
                     if (st_ff.cidx < uuid_len_ff) begin
                        if (in_byte_ff != chunk_byte) begin
                           nx.cmatch = 1'b0;
                        end
                        nx.cidx = cidx_inc;
                     end
                  end
                  nx.remain = st_ff.remain - 8'd1;
                  if (st_ff.remain == 8'd1) begin
                     do_commit = 1'b1;
                     c_plen    = st_ff.pos - st_ff.dstart + 8'd1;
                     nx.phase  = PH_LEN;
                  end
               end
               default: nx.phase = PH_LEN;
            endcase
         end
         nx.pos = st_ff.pos + 8'd1;
      end

      if (do_commit) begin
         if (c_ty == AD_NAME_FULL && !st_ff.full_found) begin
            nx.full_found = 1'b1;
            nx.full_off   = c_start;
            nx.full_len   = c_plen;
         end else if (c_ty == AD_NAME_SHORT && !st_ff.short_found) begin
            nx.short_found = 1'b1;
            nx.short_off   = c_start;
            nx.short_len   = c_plen;
         end
         if (ulen_ok) begin
            if (c_ty == t_full && !st_ff.seen[0]) begin
               nx.seen[0] = 1'b1;
               if (nx.rhit) begin
                  nx.svc_hit = 1'b1;
               end
            end else if (c_ty == t_part && !st_ff.seen[1]) begin
               nx.seen[1] = 1'b1;
               if (nx.rhit) begin
                  nx.svc_hit = 1'b1;
               end
            end else if (c_ty == t_sdata && !st_ff.sd_done) begin
               if (c_plen < ulen8) begin
                  // too short to hold the uuid: search ends empty
                  nx.sd_done = 1'b1;
               end else if (nx.cmatch) begin
                  nx.sd_done  = 1'b1;
                  nx.sd_found = 1'b1;
                  nx.sd_off   = c_start + ulen8;
                  nx.sd_len   = c_plen - ulen8;
               end
            end
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      if (advance) begin
         st_in = in_last_ff ? PKT_CLEAR : nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= PKT_CLEAR;
      end else begin
         st_ff <= st_in;
      end
   end

   // ------------------------------------------------------------ result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         if (nx.full_found && nx.full_len != 8'd0) begin
            name_off_ff <= nx.full_off;
            name_len_ff <= nx.full_len;
         end else if (nx.short_found && nx.short_len != 8'd0) begin
            name_off_ff <= nx.short_off;
            name_len_ff <= nx.short_len;
         end else begin
            name_off_ff <= 8'd0;
            name_len_ff <= 8'd0;
         end
         has_svc_ff  <= nx.svc_hit;
         sd_found_ff <= nx.sd_found;
         sd_off_ff   <= nx.sd_found ? nx.sd_off : 8'd0;
         sd_len_ff   <= nx.sd_found ? nx.sd_len : 8'd0;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.name_offset         = name_off_ff;
   assign rsp_chan.name_length         = name_len_ff;
   assign rsp_chan.has_service         = has_svc_ff;
   assign rsp_chan.service_data_found  = sd_found_ff;
   assign rsp_chan.service_data_offset = sd_off_ff;
   assign rsp_chan.service_data_length = sd_len_ff;

   // --------------------------------------------------------- assertions
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid_ff)
      else $error("last byte processed without a result");

   a_stop_in_len: assert property (@(posedge clock) disable iff (reset)
      st_ff.stopped |-> st_ff.phase == PH_LEN)
      else $error("parser stopped outside length phase");

   a_cidx_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.cidx <= 5'd16)
      else $error("chunk index past uuid size");

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      st_ff.pos <= MAX_POS)
      else $error("byte position past saturation");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      st_ff.sd_found |-> st_ff.sd_done)
      else $error("service data found without search done");

endmodule

`default_nettype wire
